@@ rtl/bdc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdc_pkg
// Types, calendar tables and helper functions for the BCD date/time codec.
// ----------------------------------------------------------------------------
package bdc_pkg;

  typedef struct packed {
    logic        func;
    logic [7:0]  year_bcd;
    logic [7:0]  month_bcd;
    logic [7:0]  day_bcd;
    logic [7:0]  hour_bcd;
    logic [7:0]  minute_bcd;
    logic [7:0]  second_bcd;
    logic [31:0] seconds_in;
  } bdc_in_t;

  typedef struct packed {
    logic [31:0] seconds_out;
    logic [7:0]  out_year_bcd;
    logic [7:0]  out_month_bcd;
    logic [7:0]  out_day_bcd;
    logic [7:0]  out_hour_bcd;
    logic [7:0]  out_minute_bcd;
    logic [7:0]  out_second_bcd;
    logic        range_error;
  } bdc_out_t;

  localparam int unsigned NumMonths = 12;

  localparam logic [8:0] MonthStartCommon [NumMonths] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] MonthStartLeap [NumMonths] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  // Reciprocals for the constant divisions (floor for the corrected ones,
  // ceiling for the exact ones).
  localparam logic [25:0] RecipDay   = 26'd50903316; // 2^35 / 675
  localparam logic [15:0] RecipQuad  = 16'd45933;    // 2^26 / 1461
  localparam logic [17:0] RecipHour  = 18'd149131;   // 2^29 / 3600
  localparam logic [12:0] RecipMin   = 13'd4370;     // 2^18 / 60
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [10:0] DaysPerQuad = 11'd1461;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] val;
    val = 9'd0;
    if (idx < 4'(NumMonths)) begin
      val = leap ? MonthStartLeap[idx] : MonthStartCommon[idx];
    end
    return val;
  endfunction

  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    return 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
  endfunction

  // Values below 100 only: tens by multiply-shift.
  function automatic logic [7:0] bcd_enc(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens * 4'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/bcd_datetime_epoch_seconds_codec.sv @@
`default_nettype none
// Throughput: one beat per cycle while out_ready_i does not stall the result,
// set by an eight-stage pipeline of constant multiplies and compares; each
// stage advances while it is empty or its successor advances. Reset clears
// all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// bcd_datetime_epoch_seconds_codec
// BCD calendar fields to and from seconds since the start of year 2000.
// ----------------------------------------------------------------------------
module bcd_datetime_epoch_seconds_codec
  import bdc_pkg::*;
#(
  parameter int unsigned YEAR_SPAN = 100
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bdc_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output bdc_out_t      out_data_o
);

  localparam logic [15:0] DayLimit = 16'(YEAR_SPAN * 365 + (YEAR_SPAN + 3) / 4);
  localparam int unsigned NumStages = 7;

  typedef struct packed {
    logic        func;
    logic        bad_month;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [31:0] acc;
    logic [31:0] secs_in;
    logic [50:0] prod_day;
    logic [15:0] days;
    logic [17:0] rem;
    logic        range_err;
    logic [31:0] prod_quad;
    logic [34:0] prod_hour;
    logic [5:0]  quad;
    logic [11:0] quad_rem;
    logic [4:0]  hr;
    logic [11:0] rem_hour;
    logic [1:0]  yr_in_quad;
    logic [8:0]  doy;
    logic [24:0] prod_min;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [5:0]  mday;
    logic [5:0]  mn;
    logic [5:0]  sc;
  } pipe_t;

  pipe_t    st_q [NumStages];
  pipe_t    st_d [NumStages];
  logic     vld_q [NumStages];
  logic     en    [NumStages];
  logic     out_vld_q;
  logic     out_en;
  bdc_out_t out_q, out_d;

  // Stage enables ripple back from the output register.
  always_comb begin
    out_en = !out_vld_q || out_ready_i;
    en[NumStages-1] = !vld_q[NumStages-1] || out_en;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  // Stage 1: decode, day count, day reciprocal product
  always_comb begin
    logic [7:0] y, m, d;
    logic [8:0] ms;
    st_d[0] = '0;
    y  = bcd_dec(in_data_i.year_bcd);
    m  = bcd_dec(in_data_i.month_bcd);
    d  = bcd_dec(in_data_i.day_bcd);
    ms = month_start(y[1:0] == 2'd0, 4'(m - 8'd1));
    st_d[0].func      = in_data_i.func;
    st_d[0].bad_month = (m == 8'd0) || (m > 8'd12);
    st_d[0].hour      = bcd_dec(in_data_i.hour_bcd);
    st_d[0].minute    = bcd_dec(in_data_i.minute_bcd);
    st_d[0].second    = bcd_dec(in_data_i.second_bcd);
    st_d[0].acc       = 32'(17'(y) * 17'd365 + 17'((9'(y) + 9'd3) >> 2)
                          + 17'(ms) + 17'(8'(d - 8'd1)));
    st_d[0].secs_in   = in_data_i.seconds_in;
    st_d[0].prod_day  = 51'(in_data_i.seconds_in[31:7]) * 51'(RecipDay);
  end

  // Stage 2: hours; estimated day count and remainder
  always_comb begin
    logic [15:0] q;
    st_d[1] = st_q[0];
    q = st_q[0].prod_day[50:35];
    st_d[1].acc  = 32'(st_q[0].acc * 32'd24) + 32'(st_q[0].hour);
    st_d[1].days = q;
    st_d[1].rem  = 18'(st_q[0].secs_in - 32'(q) * 32'(SecsPerDay));
  end

  // Stage 3: minutes; correct the day estimate, range check
  always_comb begin
    logic [15:0] days;
    st_d[2] = st_q[1];
    st_d[2].acc = 32'(st_q[1].acc * 32'd60) + 32'(st_q[1].minute);
    days = st_q[1].days;
    if (st_q[1].rem >= 18'(SecsPerDay)) begin
      days = days + 16'd1;
      st_d[2].rem = st_q[1].rem - 18'(SecsPerDay);
    end
    st_d[2].days      = days;
    st_d[2].range_err = days >= DayLimit;
  end

  // Stage 4: seconds; four-year block and hour products
  always_comb begin
    st_d[3] = st_q[2];
    st_d[3].acc       = 32'(st_q[2].acc * 32'd60) + 32'(st_q[2].second);
    st_d[3].prod_quad = 32'(st_q[2].days) * 32'(RecipQuad);
    st_d[3].prod_hour = 35'(st_q[2].rem[16:0]) * 35'(RecipHour);
  end

  // Stage 5: block estimate, hour and seconds within the hour
  always_comb begin
    logic [5:0] a;
    logic [4:0] h;
    st_d[4] = st_q[3];
    a = st_q[3].prod_quad[31:26];
    h = st_q[3].prod_hour[33:29];
    st_d[4].quad     = a;
    st_d[4].quad_rem = 12'(st_q[3].days - 16'(a) * 16'(DaysPerQuad));
    st_d[4].hr       = h;
    st_d[4].rem_hour = 12'(st_q[3].rem[16:0] - 17'(h) * 17'd3600);
  end

  // Stage 6: correct the block, split into year and day of year
  always_comb begin
    logic [11:0] r;
    st_d[5] = st_q[4];
    r = st_q[4].quad_rem;
    if (r >= 12'(DaysPerQuad)) begin
      st_d[5].quad = st_q[4].quad + 6'd1;
      r = r - 12'(DaysPerQuad);
    end
    // The block opens with the leap year.
    if (r < 12'd366) begin
      st_d[5].yr_in_quad = 2'd0;
      st_d[5].doy = 9'(r);
    end else if (r < 12'd731) begin
      st_d[5].yr_in_quad = 2'd1;
      st_d[5].doy = 9'(r - 12'd366);
    end else if (r < 12'd1096) begin
      st_d[5].yr_in_quad = 2'd2;
      st_d[5].doy = 9'(r - 12'd731);
    end else begin
      st_d[5].yr_in_quad = 2'd3;
      st_d[5].doy = 9'(r - 12'd1096);
    end
    st_d[5].prod_min = 25'(st_q[4].rem_hour) * 25'(RecipMin);
  end

  // Stage 7: year, month search, minute and second
  always_comb begin
    logic       leap;
    logic [3:0] cnt;
    logic [5:0] mn;
    st_d[6] = st_q[5];
    leap = st_q[5].yr_in_quad == 2'd0;
    cnt  = 4'd0;
    for (int i = 1; i < NumMonths; i++) begin
      if (st_q[5].doy >= month_start(leap, 4'(i))) cnt = cnt + 4'd1;
    end
    mn = st_q[5].prod_min[23:18];
    st_d[6].year  = {st_q[5].quad, 2'b00} + 8'(st_q[5].yr_in_quad);
    st_d[6].month = cnt + 4'd1;
    st_d[6].mday  = 6'(st_q[5].doy - month_start(leap, cnt) + 9'd1);
    st_d[6].mn    = mn;
    st_d[6].sc    = 6'(st_q[5].rem_hour - 12'(mn) * 12'd60);
  end

  // Stage 8: select direction and encode
  always_comb begin
    pipe_t p;
    p = st_q[NumStages-1];
    out_d = '0;
    if (!p.func) begin
      out_d.range_error = p.bad_month;
      out_d.seconds_out = p.bad_month ? 32'd0 : p.acc;
    end else begin
      out_d.range_error = p.range_err;
      if (!p.range_err) begin
        out_d.out_year_bcd   = bcd_enc(p.year[6:0]);
        out_d.out_month_bcd  = bcd_enc(7'(p.month));
        out_d.out_day_bcd    = bcd_enc(7'(p.mday));
        out_d.out_hour_bcd   = bcd_enc(7'(p.hr));
        out_d.out_minute_bcd = bcd_enc(7'(p.mn));
        out_d.out_second_bcd = bcd_enc(7'(p.sc));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStages; i++) vld_q[i] <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
      if (out_en) out_vld_q <= vld_q[NumStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumStages; i++) begin
      if (en[i]) st_q[i] <= st_d[i];
    end
    if (out_en) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ rtl/bdc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdc_checker
// Port-level checks on the codec result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bdc_checker
  import bdc_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire bdc_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |->
      out_data_o.seconds_out == 32'd0 && out_data_o.out_year_bcd == 8'd0 &&
      out_data_o.out_month_bcd == 8'd0 && out_data_o.out_day_bcd == 8'd0)
    else $error("error beat carries nonzero fields");

  a_dir_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.seconds_out != 32'd0 |->
      out_data_o.out_month_bcd == 8'd0 && out_data_o.out_day_bcd == 8'd0)
    else $error("both directions drive the result");

  a_month_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_month_bcd != 8'd0 |->
      out_data_o.out_month_bcd <= 8'h12 && out_data_o.out_day_bcd != 8'd0 &&
      out_data_o.out_day_bcd <= 8'h31 && out_data_o.out_hour_bcd <= 8'h23)
    else $error("decoded calendar field out of range");

endmodule

bind bcd_datetime_epoch_seconds_codec bdc_checker u_bdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
